### hdl/bif_pkg.sv
package bif_pkg;

  localparam int CP_W    = 21;
  localparam int DEPTH_W = 5;
  localparam int CLS_W   = 3;
  localparam int STAT_W  = 2;
  localparam int OP_W    = 2;
  localparam int CFG_IDX_W = 3;

  // input operations
  localparam logic [OP_W-1:0] OP_PROCESS = 2'd0;
  localparam logic [OP_W-1:0] OP_FINISH  = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  // result status
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_STATE = 2'd3;

  // direction classes
  localparam logic [CLS_W-1:0] CLS_NEUTRAL = 3'd0;
  localparam logic [CLS_W-1:0] CLS_LTR     = 3'd1;
  localparam logic [CLS_W-1:0] CLS_RTL     = 3'd2;
  localparam logic [CLS_W-1:0] CLS_MIR_LTR = 3'd3;
  localparam logic [CLS_W-1:0] CLS_MIR_RTL = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_DIR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_LTR  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_RTL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PUSH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POP      = 3'd4;

  localparam logic [CP_W-1:0] RST_SET_LTR = 21'h10FFF0;
  localparam logic [CP_W-1:0] RST_SET_RTL = 21'h10FFF1;
  localparam logic [CP_W-1:0] RST_PUSH    = 21'h10FFF2;
  localparam logic [CP_W-1:0] RST_POP     = 21'h10FFF3;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_MIRROR = 2'd1,
    KIND_LTR    = 2'd2,
    KIND_RTL    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RUN_ACTIVE = 2'd0,
    RUN_ENDED  = 2'd1,
    RUN_ERROR  = 2'd2
  } run_mode_t;

  // per-cell stack control
  typedef struct packed {
    logic load;
    logic load_val;
    logic push;
    logic pop;
  } cell_cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               emitted;
    logic [CP_W-1:0]    codepoint_out;
    logic [CLS_W-1:0]   direction_class;
    logic               mirrored;
    logic               active_direction;
    logic [DEPTH_W-1:0] nesting_depth;
  } result_t;

  // range table, first match wins
  localparam int SPAN_COUNT = 29;

  localparam logic [CP_W-1:0] SPAN_LO [SPAN_COUNT] = '{
    21'h00028, 21'h0003C, 21'h0005B, 21'h0007B, 21'h02018, 21'h0201C,
    21'h02039, 21'h027E6, 21'h02772, 21'h0301A, 21'h0FF08, 21'h0FF3B,
    21'h0FF5B,
    21'h00041, 21'h00061, 21'h000C0, 21'h00370, 21'h00400, 21'h01E00,
    21'h00600, 21'h00750, 21'h008A0, 21'h0FB50, 21'h0FE70, 21'h00590,
    21'h0FB1D, 21'h00780, 21'h007C0, 21'h1E900
  };

  localparam logic [CP_W-1:0] SPAN_HI [SPAN_COUNT] = '{
    21'h00029, 21'h0003E, 21'h0005D, 21'h0007D, 21'h02019, 21'h0201D,
    21'h0203A, 21'h027EB, 21'h02773, 21'h0301B, 21'h0FF09, 21'h0FF3D,
    21'h0FF5D,
    21'h0005A, 21'h0007A, 21'h0024F, 21'h003FF, 21'h004FF, 21'h01EFF,
    21'h006FF, 21'h0077F, 21'h008FF, 21'h0FDFF, 21'h0FEFF, 21'h005FF,
    21'h0FB4F, 21'h007BF, 21'h007FF, 21'h1E95F
  };

  localparam kind_t SPAN_KIND [SPAN_COUNT] = '{
    KIND_MIRROR, KIND_MIRROR, KIND_MIRROR, KIND_MIRROR, KIND_MIRROR,
    KIND_MIRROR, KIND_MIRROR, KIND_MIRROR, KIND_MIRROR, KIND_MIRROR,
    KIND_MIRROR, KIND_MIRROR, KIND_MIRROR,
    KIND_LTR, KIND_LTR, KIND_LTR, KIND_LTR, KIND_LTR, KIND_LTR,
    KIND_RTL, KIND_RTL, KIND_RTL, KIND_RTL, KIND_RTL, KIND_RTL,
    KIND_RTL, KIND_RTL, KIND_RTL, KIND_RTL
  };

endpackage

### hdl/bif_cell.sv
module bif_cell (
  input  logic              clk,
  input  logic              rst,
  input  bif_pkg::cell_cmd_t cmd,
  input  logic              up_bit,
  input  logic              down_bit,
  output logic              dir_bit
);
  import bif_pkg::*;

  logic dir_bit_next;

  // push: take the entry above (toward top); pop: take the one below
  always_comb begin
    priority if (cmd.load) begin
      dir_bit_next = cmd.load_val;
    end else if (cmd.push) begin
      dir_bit_next = up_bit;
    end else if (cmd.pop) begin
      dir_bit_next = down_bit;
    end else begin
      dir_bit_next = dir_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_bit <= 1'b0;
    end else begin
      dir_bit <= dir_bit_next;
    end
  end

endmodule

### hdl/bif_classify.sv
module bif_classify (
  input  logic [bif_pkg::CP_W-1:0] codepoint,
  output bif_pkg::kind_t           kind
);
  import bif_pkg::*;

  // walk from the last span up so the earliest match ends up on top
  always_comb begin
    kind = KIND_NONE;
    for (int i = SPAN_COUNT - 1; i >= 0; i--) begin
      if (codepoint >= SPAN_LO[i] && codepoint <= SPAN_HI[i]) begin
        kind = SPAN_KIND[i];
      end
    end
  end

endmodule

### hdl/bif_skid.sv
module bif_skid (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  bif_pkg::result_t in_data,
  output logic            in_stall,
  output logic            out_valid,
  output bif_pkg::result_t out_data,
  input  logic            out_stall
);
  import bif_pkg::*;

  logic    main_valid, main_valid_next;
  logic    skid_valid, skid_valid_next;
  result_t main_data, main_data_next;
  result_t skid_data, skid_data_next;
  logic    accept;
  logic    take;

  // skid only fills while the main stage is held, so stall is registered
  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign take      = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  always_comb begin
    main_valid_next = main_valid;
    skid_valid_next = skid_valid;
    main_data_next  = main_data;
    skid_data_next  = skid_data;
    if (take || !main_valid) begin
      if (skid_valid) begin
        main_valid_next = 1'b1;
        main_data_next  = skid_data;
        skid_valid_next = 1'b0;
      end else begin
        main_valid_next = accept;
        main_data_next  = in_data;
      end
    end else if (accept) begin
      skid_valid_next = 1'b1;
      skid_data_next  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      main_valid <= main_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    main_data <= main_data_next;
    skid_data <= skid_data_next;
  end

endmodule

### hdl/bidi_isolate_framer.sv
// Bidirectional isolate framer. Each input transaction carries an op (process,
// finish, restart) and a codepoint; each one yields exactly one result
// transaction. Throughput is one transaction per clock while in_stall is low:
// the isolate direction stack is a row of MAX_NESTING one-bit cells that shift
// toward the bottom on a push and toward the top on a pop, so the top of stack
// is always cell 0 and no indexed read is needed. Classification is a parallel
// bank of range comparators over the fixed span table. An accepted input's
// result is registered in a two-entry output buffer (result register plus
// skid slot), which lets one more input be accepted while the result side
// stalls, and in_stall comes straight from a flop. The configuration port may
// only be written while no transaction is in flight. Directive codes are
// compared before the range table, with priority set-LTR, set-RTL, push, pop.
// Push on a full stack or pop of the root latches an error; afterwards only
// restart recovers. nesting_depth shows the stack count truncated to 5 bits.
module bidi_isolate_framer #(
  parameter int MAX_NESTING = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [bif_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bif_pkg::CP_W-1:0]      cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bif_pkg::OP_W-1:0]      op,
  input  logic [bif_pkg::CP_W-1:0]      codepoint,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bif_pkg::STAT_W-1:0]    status,
  output logic                          emitted,
  output logic [bif_pkg::CP_W-1:0]      codepoint_out,
  output logic [bif_pkg::CLS_W-1:0]     direction_class,
  output logic                          mirrored,
  output logic                          active_direction,
  output logic [bif_pkg::DEPTH_W-1:0]   nesting_depth
);
  import bif_pkg::*;

  localparam int CNT_W = $clog2(MAX_NESTING + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_NESTING);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic            init_dir;
  logic [CP_W-1:0] set_ltr_code;
  logic [CP_W-1:0] set_rtl_code;
  logic [CP_W-1:0] push_code;
  logic [CP_W-1:0] pop_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      init_dir     <= 1'b0;
      set_ltr_code <= RST_SET_LTR;
      set_rtl_code <= RST_SET_RTL;
      push_code    <= RST_PUSH;
      pop_code     <= RST_POP;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_INIT_DIR: init_dir     <= cfg_data[0];
        CFG_SET_LTR:  set_ltr_code <= cfg_data;
        CFG_SET_RTL:  set_rtl_code <= cfg_data;
        CFG_PUSH:     push_code    <= cfg_data;
        CFG_POP:      pop_code     <= cfg_data;
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  run_mode_t        run_mode, run_mode_next;
  logic [CNT_W-1:0] stack_count, stack_count_next;
  logic             accept;
  logic             is_active;

  logic             cell_bit [MAX_NESTING];
  logic             top_bit;
  logic             second_bit;

  assign accept     = in_valid && !in_stall;
  assign is_active  = (run_mode == RUN_ACTIVE);
  assign top_bit    = cell_bit[0];
  assign second_bit = cell_bit[1];

  // directive decode, priority order set-LTR, set-RTL, push, pop
  logic hit_ltr, hit_rtl, hit_push, hit_pop, hit_any;
  logic stack_full, stack_root;

  assign hit_ltr  = (codepoint == set_ltr_code);
  assign hit_rtl  = !hit_ltr && (codepoint == set_rtl_code);
  assign hit_push = !hit_ltr && !hit_rtl && (codepoint == push_code);
  assign hit_pop  = !hit_ltr && !hit_rtl && !hit_push && (codepoint == pop_code);
  assign hit_any  = hit_ltr || hit_rtl || hit_push || hit_pop;

  assign stack_full = (stack_count == CNT_MAX);
  assign stack_root = (stack_count == CNT_ONE);

  logic do_process;
  assign do_process = accept && (op == OP_PROCESS) && is_active;

  // next run mode
  always_comb begin
    run_mode_next = run_mode;
    if (accept) begin
      unique case (op)
        OP_RESTART: run_mode_next = RUN_ACTIVE;
        OP_FINISH: begin
          if (run_mode != RUN_ERROR) begin
            run_mode_next = RUN_ENDED;
          end
        end
        OP_PROCESS: begin
          if (is_active && ((hit_push && stack_full) || (hit_pop && stack_root))) begin
            run_mode_next = RUN_ERROR;
          end
        end
        default: ;  // unused op: no effect
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode    <= RUN_ACTIVE;
      stack_count <= CNT_ONE;
    end else begin
      run_mode    <= run_mode_next;
      stack_count <= stack_count_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stack commands and result
  // ---------------------------------------------------------------------------
  kind_t   kind;
  logic    do_restart, do_set, set_val, do_push, do_pop;
  result_t step_res;

  bif_classify u_classify (
    .codepoint (codepoint),
    .kind      (kind)
  );

  always_comb begin
    do_restart       = accept && (op == OP_RESTART);
    do_set           = do_process && (hit_ltr || hit_rtl);
    set_val          = hit_rtl;
    do_push          = do_process && hit_push && !stack_full;
    do_pop           = do_process && hit_pop && !stack_root;
    stack_count_next = stack_count;

    step_res                 = '0;
    step_res.status          = ST_OK;
    step_res.direction_class = CLS_NEUTRAL;

    priority if (do_restart) begin
      stack_count_next = CNT_ONE;
    end else if (do_push) begin
      stack_count_next = CNT_W'(stack_count + CNT_ONE);
    end else if (do_pop) begin
      stack_count_next = CNT_W'(stack_count - CNT_ONE);
    end else begin
      stack_count_next = stack_count;
    end

    unique case (op)
      OP_FINISH: begin
        if (run_mode == RUN_ERROR) begin
          step_res.status = ST_BAD_STATE;
        end
      end
      OP_PROCESS: begin
        if (!is_active) begin
          step_res.status = ST_BAD_STATE;
        end else if (hit_push && stack_full) begin
          step_res.status = ST_OVERFLOW;
        end else if (hit_pop && stack_root) begin
          step_res.status = ST_UNDERFLOW;
        end else if (!hit_any) begin
          step_res.emitted       = 1'b1;
          step_res.codepoint_out = codepoint;
          unique case (kind)
            KIND_MIRROR: begin
              step_res.mirrored        = 1'b1;
              step_res.direction_class = top_bit ? CLS_MIR_RTL : CLS_MIR_LTR;
            end
            KIND_RTL:  step_res.direction_class = CLS_RTL;
            KIND_LTR:  step_res.direction_class = CLS_LTR;
            default:   step_res.direction_class = CLS_NEUTRAL;
          endcase
        end
      end
      default: ;  // restart and unused op report OK
    endcase

    // top of stack after the step
    priority if (do_restart) begin
      step_res.active_direction = init_dir;
    end else if (do_set) begin
      step_res.active_direction = set_val;
    end else if (do_pop) begin
      step_res.active_direction = second_bit;
    end else begin
      step_res.active_direction = top_bit;
    end
    step_res.nesting_depth = DEPTH_W'(stack_count_next);
  end

  // row of stack cells, cell 0 is the top of stack
  for (genvar i = 0; i < MAX_NESTING; i++) begin : g_cell
    cell_cmd_t cmd;
    logic      up_bit;
    logic      down_bit;

    if (i == 0) begin : g_top
      assign up_bit   = cell_bit[0];  // push keeps a copy on top
      assign cmd.load = do_restart || do_set;
      assign cmd.load_val = do_restart ? init_dir : set_val;
    end else begin : g_lower
      assign up_bit   = cell_bit[i-1];
      assign cmd.load = do_restart;
      assign cmd.load_val = 1'b0;
    end

    if (i == MAX_NESTING - 1) begin : g_bottom
      assign down_bit = 1'b0;
    end else begin : g_inner
      assign down_bit = cell_bit[i+1];
    end

    assign cmd.push = do_push;
    assign cmd.pop  = do_pop;

    bif_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .up_bit   (up_bit),
      .down_bit (down_bit),
      .dir_bit  (cell_bit[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Output buffer
  // ---------------------------------------------------------------------------
  result_t out_res;

  bif_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_data   (step_res),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_res),
    .out_stall (out_stall)
  );

  assign status           = out_res.status;
  assign emitted          = out_res.emitted;
  assign codepoint_out    = out_res.codepoint_out;
  assign direction_class  = out_res.direction_class;
  assign mirrored         = out_res.mirrored;
  assign active_direction = out_res.active_direction;
  assign nesting_depth    = out_res.nesting_depth;

endmodule

### hdl/bif_checker.sv
module bif_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bif_pkg::STAT_W-1:0]    status,
  input logic                          emitted,
  input logic [bif_pkg::CP_W-1:0]      codepoint_out,
  input logic [bif_pkg::CLS_W-1:0]     direction_class,
  input logic                          mirrored,
  input logic                          active_direction
);
  import bif_pkg::*;

  // buffer comes out of reset empty and open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

  // skid slot can only be occupied behind a held result
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  a_no_emit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !emitted |->
      codepoint_out == '0 && direction_class == CLS_NEUTRAL && !mirrored)
    else $error("payload fields set without emission");

  // mirrored glyphs follow the innermost isolate direction
  a_mirror_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && mirrored |->
      emitted && status == ST_OK &&
      direction_class == (active_direction ? CLS_MIR_RTL : CLS_MIR_LTR))
    else $error("mirrored class disagrees with active direction");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(codepoint_out) && $stable(status))
    else $error("stalled result changed");

endmodule

bind bidi_isolate_framer bif_checker u_bif_checker (
  .clk              (clk),
  .rst              (rst),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .status           (status),
  .emitted          (emitted),
  .codepoint_out    (codepoint_out),
  .direction_class  (direction_class),
  .mirrored         (mirrored),
  .active_direction (active_direction)
);
